@@ hdl/nwa_pkg.sv @@
// Shared types and codes for the NFA word acceptor.
// Used by nwa_advance, nfa_word_acceptor_top, nwa_checker and the testbench; depends on nothing.
package nwa_pkg;

    // input operation codes
    typedef logic [1:0] t_op;
    localparam t_op OP_CLEAR  = 2'd0;
    localparam t_op OP_ADD    = 2'd1;
    localparam t_op OP_SYMBOL = 2'd2;
    localparam t_op OP_END    = 2'd3;

    // result status codes
    localparam logic STATUS_VERDICT = 1'b0;
    localparam logic STATUS_FULL    = 1'b1;

    // configuration register indexes (register i at byte address 4*i)
    localparam logic REG_START_STATE = 1'b0;
    localparam logic REG_FINAL_MASK  = 1'b1;

    // fixed field widths
    localparam int STATE_BITS     = 4;
    localparam int SYM_FIELD_BITS = 8;
    localparam int FINAL_BITS     = 16;
    localparam int CFG_DATA_BITS  = 32;
    localparam int CFG_ADDR_BITS  = 3;

    // endpoints of one stored edge
    typedef struct packed {
        logic [STATE_BITS-1:0] src;
        logic [STATE_BITS-1:0] dst;
    } t_edge;

endpackage

@@ hdl/nwa_advance.sv @@
// Next active state set: matches every stored edge against the current
// set and symbol in parallel. Depends on nwa_pkg.
module nwa_advance #(
    parameter int NUM_STATES = 16,
    parameter int MAX_EDGES  = 64,
    parameter int SYM_W      = 8,
    parameter int CNT_W      = 7
) (
    input  logic [NUM_STATES-1:0] i_set,
    input  logic [SYM_W-1:0]      i_sym,
    input  nwa_pkg::t_edge        i_edges    [MAX_EDGES],
    input  logic [SYM_W-1:0]      i_edge_sym [MAX_EDGES],
    input  logic [CNT_W-1:0]      i_edge_count,
    output logic [NUM_STATES-1:0] o_set
);
    import nwa_pkg::*;

    // wide enough that any 4-bit state index lands inside the vector
    localparam int SPAN = (NUM_STATES > (1 << STATE_BITS)) ? NUM_STATES : (1 << STATE_BITS);

    logic [SPAN-1:0] set_ext;
    logic [SPAN-1:0] next_ext;

    always_comb begin
        set_ext  = SPAN'(i_set);
        next_ext = '0;
        for (int i = 0; i < MAX_EDGES; i++) begin
            // only entries below the fill count are live
            if ((CNT_W'(i) < i_edge_count) && (i_edge_sym[i] == i_sym)
                && set_ext[i_edges[i].src]) begin
                next_ext[i_edges[i].dst] = 1'b1;
            end
        end
    end

    // destinations beyond NUM_STATES drop out here
    assign o_set = next_ext[NUM_STATES-1:0];

endmodule

@@ hdl/nfa_word_acceptor_top.sv @@
// NFA word acceptor: an input transaction goes from the input register to the result
// register. Throughput 1 item per cycle while the result channel does not stall; the
// edge table is matched in full combinationally between the two registers.
// Reset is synchronous, active low: clears edge count, word state, active set,
// configuration and valid flags. Edge table contents are not cleared.
// Depends on nwa_pkg and nwa_advance.
module nfa_word_acceptor_top #(
    parameter int NUM_STATES  = 16,
    parameter int MAX_EDGES   = 64,
    parameter int SYMBOL_BITS = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  nwa_pkg::t_op                        i_op,
    input  logic [nwa_pkg::STATE_BITS-1:0]      i_edge_from,
    input  logic [nwa_pkg::STATE_BITS-1:0]      i_edge_to,
    input  logic [nwa_pkg::SYM_FIELD_BITS-1:0]  i_symbol,
    // result channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_status,
    output logic                                o_accepted,
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [nwa_pkg::CFG_ADDR_BITS-1:0]   paddr,
    input  logic [nwa_pkg::CFG_DATA_BITS-1:0]   pwdata,
    output logic [nwa_pkg::CFG_DATA_BITS-1:0]   prdata,
    output logic                                pready
);
    import nwa_pkg::*;

    localparam int SYM_W = (SYMBOL_BITS < SYM_FIELD_BITS) ? SYMBOL_BITS : SYM_FIELD_BITS;
    localparam int CNT_W = $clog2(MAX_EDGES + 1);
    localparam int IDX_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int SPAN  = (NUM_STATES > (1 << STATE_BITS)) ? NUM_STATES : (1 << STATE_BITS);

    // configuration
    logic [STATE_BITS-1:0] r_start_state;
    logic [FINAL_BITS-1:0] r_final_mask;
    logic                  cfg_wr;

    // input register
    logic                      r_in_valid;
    t_op                       r_op;
    logic [STATE_BITS-1:0]     r_from;
    logic [STATE_BITS-1:0]     r_to;
    logic [SYM_FIELD_BITS-1:0] r_sym;

    // automaton state
    t_edge                 r_edges    [MAX_EDGES];
    logic [SYM_W-1:0]      r_edge_sym [MAX_EDGES];
    logic [CNT_W-1:0]      r_edge_count, n_edge_count;
    logic [NUM_STATES-1:0] r_active, n_active;
    logic                  r_in_word, n_in_word;

    // result register
    logic r_out_valid, n_out_valid;
    logic r_status, n_status;
    logic r_accepted, n_accepted;

    logic                  proc;
    logic                  full;
    logic                  edge_wr;
    logic [IDX_W-1:0]      wr_idx;
    logic [SPAN-1:0]       start_ext;
    logic [NUM_STATES-1:0] cur_set;
    logic [NUM_STATES-1:0] adv_set;
    logic                  verdict;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_FINAL_MASK) ? CFG_DATA_BITS'(r_final_mask)
                                                 : CFG_DATA_BITS'(r_start_state);

    // stage fires when the result slot is free or being drained
    assign proc       = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !proc;

    assign full    = (r_edge_count == CNT_W'(MAX_EDGES));
    assign edge_wr = proc && (r_op == OP_ADD) && !full;
    assign wr_idx  = r_edge_count[IDX_W-1:0];

    // a new word starts from the start state alone
    assign start_ext = SPAN'(1'b1) << r_start_state;
    assign cur_set   = r_in_word ? r_active : start_ext[NUM_STATES-1:0];
    assign verdict   = |(SPAN'(cur_set) & SPAN'(r_final_mask));

    nwa_advance #(
        .NUM_STATES (NUM_STATES),
        .MAX_EDGES  (MAX_EDGES),
        .SYM_W      (SYM_W),
        .CNT_W      (CNT_W)
    ) u_advance (
        .i_set        (cur_set),
        .i_sym        (r_sym[SYM_W-1:0]),
        .i_edges      (r_edges),
        .i_edge_sym   (r_edge_sym),
        .i_edge_count (r_edge_count),
        .o_set        (adv_set)
    );

    always_comb begin
        n_edge_count = r_edge_count;
        n_active     = r_active;
        n_in_word    = r_in_word;
        n_out_valid  = r_out_valid && i_out_stall;
        n_status     = r_status;
        n_accepted   = r_accepted;
        if (proc) begin
            case (r_op)
                OP_CLEAR: begin
                    n_edge_count = '0;
                end
                OP_ADD: begin
                    if (full) begin
                        n_out_valid = 1'b1;
                        n_status    = STATUS_FULL;
                        n_accepted  = 1'b0;
                    end else begin
                        n_edge_count = r_edge_count + CNT_W'(1);
                    end
                end
                OP_SYMBOL: begin
                    n_active  = adv_set;
                    n_in_word = 1'b1;
                end
                OP_END: begin
                    n_out_valid = 1'b1;
                    n_status    = STATUS_VERDICT;
                    n_accepted  = verdict;
                    n_in_word   = 1'b0;
                end
                default: begin
                    n_edge_count = r_edge_count;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_edge_count  <= '0;
            r_active      <= '0;
            r_in_word     <= 1'b0;
            r_start_state <= '0;
            r_final_mask  <= '0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            r_out_valid  <= n_out_valid;
            r_edge_count <= n_edge_count;
            r_active     <= n_active;
            r_in_word    <= n_in_word;
            if (cfg_wr) begin
                if (paddr[2] == REG_FINAL_MASK) begin
                    r_final_mask <= pwdata[FINAL_BITS-1:0];
                end else begin
                    r_start_state <= pwdata[STATE_BITS-1:0];
                end
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_op   <= i_op;
            r_from <= i_edge_from;
            r_to   <= i_edge_to;
            r_sym  <= i_symbol;
        end
        r_status   <= n_status;
        r_accepted <= n_accepted;
        if (edge_wr) begin
            r_edges[wr_idx].src <= r_from;
            r_edges[wr_idx].dst <= r_to;
            r_edge_sym[wr_idx]  <= r_sym[SYM_W-1:0];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_accepted  = r_accepted;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_edge_count <= CNT_W'(MAX_EDGES))
        else $error("edge count beyond table depth");

    a_full_no_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == STATUS_FULL)) |-> !o_accepted)
        else $error("overflow result carries a verdict");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc && (r_op == OP_CLEAR)) |=> (r_edge_count == '0))
        else $error("clear did not empty the edge table");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid && i_out_stall))
        else $error("input stalled without a blocked result");
`endif

endmodule

@@ tb/sv/nwa_checker.sv @@
`timescale 1ns / 100ps
// Scoreboard for nfa_word_acceptor_top: follows APB register writes, predicts the
// verdict and table-full transactions from accepted inputs, compares the result channel.
// Depends on nwa_pkg.
module nwa_checker #(
    parameter int NUM_STATES  = 16,
    parameter int MAX_EDGES   = 64,
    parameter int SYMBOL_BITS = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_stall,
    input  nwa_pkg::t_op                        i_op,
    input  logic [nwa_pkg::STATE_BITS-1:0]      i_edge_from,
    input  logic [nwa_pkg::STATE_BITS-1:0]      i_edge_to,
    input  logic [nwa_pkg::SYM_FIELD_BITS-1:0]  i_symbol,
    input  logic                                i_out_valid,
    input  logic                                i_out_stall,
    input  logic                                i_status,
    input  logic                                i_accepted,
    input  logic                                i_psel,
    input  logic                                i_penable,
    input  logic                                i_pwrite,
    input  logic                                i_pready,
    input  logic [nwa_pkg::CFG_ADDR_BITS-1:0]   i_paddr,
    input  logic [nwa_pkg::CFG_DATA_BITS-1:0]   i_pwdata,
    output int                                  o_mismatches,
    output int                                  o_outstanding
);
    import nwa_pkg::*;

    localparam logic [SYM_FIELD_BITS-1:0] SYM_MASK =
        SYM_FIELD_BITS'((64'd1 << SYMBOL_BITS) - 64'd1);

    typedef struct packed {
        logic status;
        logic accepted;
    } t_verdict;

    t_verdict                   verdict_q[$];
    logic [STATE_BITS-1:0]      tab_src [MAX_EDGES];
    logic [STATE_BITS-1:0]      tab_dst [MAX_EDGES];
    logic [SYM_FIELD_BITS-1:0]  tab_sym [MAX_EDGES];
    int                         edge_cnt = 0;
    logic [NUM_STATES-1:0]      live_states = '0;
    logic                       in_word = 1'b0;
    logic [STATE_BITS-1:0]      start_reg = '0;
    logic [FINAL_BITS-1:0]      final_reg = '0;
    int                         mismatches = 0;

    // out-of-range state indexes map to no state at all
    function automatic logic [NUM_STATES-1:0] state_onehot(input logic [STATE_BITS-1:0] s);
        logic [NUM_STATES-1:0] v;
        v = '0;
        if (int'(s) < NUM_STATES) v[s] = 1'b1;
        return v;
    endfunction

    function automatic logic [NUM_STATES-1:0] next_states(
        input logic [NUM_STATES-1:0]     cur,
        input logic [SYM_FIELD_BITS-1:0] sym
    );
        logic [NUM_STATES-1:0] nxt;
        int i;
        nxt = '0;
        for (i = 0; i < edge_cnt; i++) begin
            if (((tab_sym[i] ^ sym) & SYM_MASK) == '0 &&
                (cur & state_onehot(tab_src[i])) != '0)
                nxt |= state_onehot(tab_dst[i]);
        end
        return nxt;
    endfunction

    task automatic take_item(
        input t_op                       op,
        input logic [STATE_BITS-1:0]     from,
        input logic [STATE_BITS-1:0]     to,
        input logic [SYM_FIELD_BITS-1:0] sym
    );
        t_verdict v;
        case (op)
            OP_CLEAR: edge_cnt = 0;
            OP_ADD: begin
                if (edge_cnt < MAX_EDGES) begin
                    tab_src[edge_cnt] = from;
                    tab_dst[edge_cnt] = to;
                    tab_sym[edge_cnt] = sym;
                    edge_cnt++;
                end else begin
                    v.status   = STATUS_FULL;
                    v.accepted = 1'b0;
                    verdict_q.insert(verdict_q.size(), v);
                end
            end
            default: begin
                if (!in_word) begin
                    live_states = state_onehot(start_reg);
                    in_word     = 1'b1;
                end
                if (op == OP_SYMBOL) begin
                    live_states = next_states(live_states, sym);
                end else begin
                    v.status   = STATUS_VERDICT;
                    v.accepted = |(live_states & NUM_STATES'(final_reg));
                    verdict_q.insert(verdict_q.size(), v);
                    in_word = 1'b0;
                end
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        t_verdict want;
        if (!i_rst_n) begin
            verdict_q.delete();
            edge_cnt    = 0;
            live_states = '0;
            in_word     = 1'b0;
            start_reg   = '0;
            final_reg   = '0;
        end else begin
            // results first: nothing accepted on this edge can already have a result
            if (i_out_valid && !i_out_stall) begin
                if (verdict_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"[%0t] result transaction with none expected: ",
                                  "status=%0b accepted=%0b"},
                                 $time, i_status, i_accepted);
                end else begin
                    want = verdict_q.pop_front();
                    if (i_status !== want.status || i_accepted !== want.accepted) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"[%0t] result mismatch: expected status=%0b ",
                                      "accepted=%0b, got status=%0b accepted=%0b"},
                                     $time, want.status, want.accepted,
                                     i_status, i_accepted);
                    end
                end
            end
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[2])
                    REG_START_STATE: start_reg = i_pwdata[STATE_BITS-1:0];
                    REG_FINAL_MASK:  final_reg = i_pwdata[FINAL_BITS-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall)
                take_item(i_op, i_edge_from, i_edge_to, i_symbol);
        end
        o_outstanding <= verdict_q.size();
        o_mismatches  <= mismatches;
    end

endmodule

@@ tb/sv/tb_nfa_word_acceptor_top.sv @@
`timescale 1ns / 100ps
// Testbench top for nfa_word_acceptor_top: drives inputs with random gaps, a random result
// stall and APB writes, instantiates nwa_checker beside the block and prints the verdict.
// Depends on nwa_pkg, nfa_word_acceptor_top and nwa_checker.
module tb_nfa_word_acceptor_top;
    import nwa_pkg::*;

    localparam int NUM_STATES  = 16;
    localparam int MAX_EDGES   = 64;
    localparam int SYMBOL_BITS = 8;
    localparam int ITEM_TARGET = 1250;
    localparam int HOLD_OFF    = 4;     // margin for the block's registers to empty
    localparam int IDLE_LIMIT  = 1000;

    logic                       i_clk     = 1'b0;
    logic                       i_rst_n   = 1'b0;
    logic                       in_valid  = 1'b0;
    t_op                        in_op     = OP_CLEAR;
    logic [STATE_BITS-1:0]      in_from   = '0;
    logic [STATE_BITS-1:0]      in_to     = '0;
    logic [SYM_FIELD_BITS-1:0]  in_sym    = '0;
    logic                       out_stall = 1'b0;
    logic                       psel      = 1'b0;
    logic                       penable   = 1'b0;
    logic                       pwrite    = 1'b0;
    logic [CFG_ADDR_BITS-1:0]   paddr     = '0;
    logic [CFG_DATA_BITS-1:0]   pwdata    = '0;

    logic                       in_stall;
    logic                       out_valid;
    logic                       status;
    logic                       accepted;
    logic [CFG_DATA_BITS-1:0]   prdata;
    logic                       pready;

    logic quiet       = 1'b0;   // no gaps or stalls while set
    int   items_sent  = 0;
    int   rx_wait     = 0;
    int   idle_cycles = 0;
    int   mismatches;
    int   outstanding;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    nfa_word_acceptor_top #(
        .NUM_STATES  (NUM_STATES),
        .MAX_EDGES   (MAX_EDGES),
        .SYMBOL_BITS (SYMBOL_BITS)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_op        (in_op),
        .i_edge_from (in_from),
        .i_edge_to   (in_to),
        .i_symbol    (in_sym),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_status    (status),
        .o_accepted  (accepted),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    nwa_checker #(
        .NUM_STATES  (NUM_STATES),
        .MAX_EDGES   (MAX_EDGES),
        .SYMBOL_BITS (SYMBOL_BITS)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_op          (in_op),
        .i_edge_from   (in_from),
        .i_edge_to     (in_to),
        .i_symbol      (in_sym),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_status      (status),
        .i_accepted    (accepted),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_pready      (pready),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    // receiver: after each result transaction, stall for a random number of cycles
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_wait = 0;
        end else if (out_valid && !out_stall) begin
            rx_wait = quiet ? 0 : $urandom_range(0, 5);
        end else if (rx_wait != 0) begin
            rx_wait--;
        end
        out_stall <= (rx_wait != 0);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic push_item(
        input t_op                       op,
        input logic [STATE_BITS-1:0]     from,
        input logic [STATE_BITS-1:0]     to,
        input logic [SYM_FIELD_BITS-1:0] sym
    );
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 5);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_op    <= op;
        in_from  <= from;
        in_to    <= to;
        in_sym   <= sym;
        do @(posedge i_clk); while (in_stall);
        items_sent++;
    endtask

    // sender stops until every expected result is back, then lets the pipe empty
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (HOLD_OFF) @(posedge i_clk);
    endtask

    // returning to idle after the access keeps back-to-back writes apart
    task automatic apb_write(input logic idx, input logic [CFG_DATA_BITS-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // upper bits are junk on purpose: the registers keep only their own width
    task automatic set_config(input logic [STATE_BITS-1:0] st, input logic [FINAL_BITS-1:0] mask);
        apb_write(REG_START_STATE, ($urandom() & ~32'hF) | 32'(st));
        apb_write(REG_FINAL_MASK, ($urandom() & ~32'hFFFF) | 32'(mask));
    endtask

    // one burst: new config, a small automaton around the start state, then words
    task automatic run_phase(input int idx);
        logic [STATE_BITS-1:0]     st;
        logic [FINAL_BITS-1:0]     mask;
        logic [SYM_FIELD_BITS-1:0] sym_base;
        int span;
        int alpha;
        int n_edges;
        int n_words;
        int len;
        drain();
        quiet = ($urandom_range(0, 3) == 0);
        case ($urandom_range(0, 3))
            0:       st = '0;
            1:       st = '1;
            default: st = STATE_BITS'($urandom());
        endcase
        case ($urandom_range(0, 4))
            0:       mask = '0;
            1:       mask = '1;
            default: mask = FINAL_BITS'($urandom());
        endcase
        set_config(st, mask);
        span     = $urandom_range(1, 5);
        alpha    = $urandom_range(1, 3);
        sym_base = SYM_FIELD_BITS'($urandom());
        if (idx == 0 || $urandom_range(0, 7) != 0)
            push_item(OP_CLEAR, STATE_BITS'($urandom()), STATE_BITS'($urandom()),
                      SYM_FIELD_BITS'($urandom()));
        // now and then fill the table past its end to get table-full results
        if (idx == 0)
            n_edges = MAX_EDGES + 6;
        else if ($urandom_range(0, 9) == 0)
            n_edges = $urandom_range(MAX_EDGES - 4, MAX_EDGES + 6);
        else
            n_edges = $urandom_range(1, 16);
        repeat (n_edges)
            push_item(OP_ADD, st + STATE_BITS'($urandom_range(0, span - 1)),
                      st + STATE_BITS'($urandom_range(0, span - 1)),
                      sym_base + SYM_FIELD_BITS'($urandom_range(0, alpha - 1)));
        n_words = $urandom_range(2, 8);
        repeat (n_words) begin
            len = $urandom_range(0, 6);
            repeat (len) begin
                if ($urandom_range(0, 15) == 0)
                    push_item(OP_SYMBOL, STATE_BITS'($urandom()), STATE_BITS'($urandom()),
                              SYM_FIELD_BITS'($urandom()));
                else
                    push_item(OP_SYMBOL, STATE_BITS'($urandom()), STATE_BITS'($urandom()),
                              sym_base + SYM_FIELD_BITS'($urandom_range(0, alpha - 1)));
            end
            push_item(OP_END, STATE_BITS'($urandom()), STATE_BITS'($urandom()),
                      SYM_FIELD_BITS'($urandom()));
            if ($urandom_range(0, 5) == 0)
                push_item(t_op'($urandom_range(0, 3)), STATE_BITS'($urandom()),
                          STATE_BITS'($urandom()), SYM_FIELD_BITS'($urandom()));
        end
    endtask

    initial begin
        int phase;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset config: empty word with no final state
        push_item(OP_END, 4'd0, 4'd0, 8'h00);
        drain();
        set_config(4'd0, 16'h8000);
        push_item(OP_END, 4'd0, 4'd0, 8'h00);       // empty word, start not final
        push_item(OP_ADD, 4'd0, 4'd15, 8'hFF);
        push_item(OP_ADD, 4'd15, 4'd15, 8'h00);
        push_item(OP_ADD, 4'd0, 4'd0, 8'h00);
        push_item(OP_SYMBOL, 4'd0, 4'd0, 8'hFF);
        push_item(OP_SYMBOL, 4'd0, 4'd0, 8'h00);
        push_item(OP_END, 4'd0, 4'd0, 8'h00);       // ends in 15: accept
        push_item(OP_SYMBOL, 4'd0, 4'd0, 8'h00);
        push_item(OP_END, 4'd0, 4'd0, 8'h00);       // ends in 0: reject
        push_item(OP_SYMBOL, 4'd15, 4'd15, 8'h5A);  // no edge: word dies
        push_item(OP_SYMBOL, 4'd0, 4'd0, 8'hFF);
        push_item(OP_END, 4'd0, 4'd0, 8'h00);
        push_item(OP_SYMBOL, 4'd0, 4'd0, 8'hFF);
        push_item(OP_CLEAR, 4'd15, 4'd15, 8'hFF);   // clear with a word in progress
        push_item(OP_ADD, 4'd15, 4'd0, 8'hA5);
        push_item(OP_SYMBOL, 4'd0, 4'd0, 8'hA5);
        push_item(OP_END, 4'd0, 4'd0, 8'h00);
        drain();
        set_config(4'd15, 16'hFFFF);
        push_item(OP_END, 4'd0, 4'd0, 8'h00);       // empty word, start is final
        push_item(OP_SYMBOL, 4'd0, 4'd0, 8'h00);
        push_item(OP_END, 4'd0, 4'd0, 8'h00);

        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            run_phase(phase);
            phase++;
        end
        drain();

        if (outstanding != 0)
            $display("%0d expected result transactions never arrived", outstanding);
        if (mismatches == 0 && outstanding == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
